FILE: rtl/flow_shop_group_makespan_top_macros.svh
// ----------------------------------------------------------------------------
// flow shop group makespan assertion macros
// shared property wrappers clocked on clock and disabled during reset
// ----------------------------------------------------------------------------
`ifndef FLOW_SHOP_GROUP_MAKESPAN_TOP_MACROS_SVH
`define FLOW_SHOP_GROUP_MAKESPAN_TOP_MACROS_SVH

// same-cycle implication
`define FSGM_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FSGM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/fsgm_pkg.sv
// ----------------------------------------------------------------------------
// fsgm_pkg
// types, constants and helpers of the flow shop group makespan block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fsgm_pkg;

   localparam int MAX_STAGES   = 4;
   localparam int MAX_MACHINES = 4;
   localparam int MAX_FAMILIES = 16;
   localparam int MAX_JOBS     = 64;
   localparam int TIME_WIDTH   = 24;

   localparam int STAGE_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
   localparam int MACH_W  = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
   localparam int FAM_W   = $clog2(MAX_FAMILIES);
   localparam int JOB_W   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int SLOT_W  = STAGE_W + MACH_W;
   localparam int NUM_SLOTS = 2 ** SLOT_W;

   localparam int SETUP_ADDR_W = STAGE_W + 2 * FAM_W;
   localparam int SETUP_DEPTH  = 2 ** SETUP_ADDR_W;
   localparam int PROC_ADDR_W  = JOB_W + STAGE_W;
   localparam int PROC_DEPTH   = 2 ** PROC_ADDR_W;

   // fixed field widths
   localparam int OP_W       = 3;
   localparam int FAMILY_W   = 4;
   localparam int STAGE_FW   = 2;
   localparam int JOB_FW     = 6;
   localparam int TVAL_W     = 16;
   localparam int OUT_W      = 24;
   localparam int CNT_W      = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 3;

   localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_STAGE_COUNT = 3'd0;
   localparam int                   REG_MACH_BASE   = 1;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_SETUP = 3'd0,
      OP_LOAD_PROC  = 3'd1,
      OP_CLEAR      = 3'd2,
      OP_BEGIN_FAM  = 3'd3,
      OP_ADD_JOB    = 3'd4
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_BEG_RD,
      ST_BEG_CMP,
      ST_BEG_WR,
      ST_JOB_RD,
      ST_JOB_UPD,
      ST_SCAN_START,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic table_write;
      logic clear_sched;
      logic beg_compare;
      logic beg_commit;
      logic job_update;
      logic scan_start;
      logic scan_step;
      logic flag_no_family;
      logic load_result;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            family_open;
      logic            last_machine;
      logic            last_stage;
      logic            last_scan;
      logic            rsp_free;
   } stat_type;

   function automatic logic [TIME_WIDTH-1:0] sat_add(input logic [TIME_WIDTH-1:0] a,
                                                     input logic [TVAL_W-1:0] b);
      logic [TIME_WIDTH:0] sum;
      sum = {1'b0, a} + (TIME_WIDTH + 1)'(b);
      return sum[TIME_WIDTH] ? TIME_MAX : sum[TIME_WIDTH-1:0];
   endfunction

   function automatic logic [CNT_W-1:0] clamp_count(input logic [CSR_DATA_W-1:0] v,
                                                    input int hi);
      logic [CNT_W-1:0] r;
      if (v == '0) begin
         r = CNT_W'(1);
      end else if (int'(v) > hi) begin
         r = CNT_W'(hi);
      end else begin
         r = CNT_W'(v);
      end
      return r;
   endfunction

endpackage

FILE: rtl/fsgm_ifs.sv
// ----------------------------------------------------------------------------
// fsgm channel interfaces
// request, response and register write channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fsgm_req_if;
   logic                            valid;
   logic                            ready;
   logic [fsgm_pkg::OP_W-1:0]       operation;
   logic [fsgm_pkg::FAMILY_W-1:0]   family_id;
   logic [fsgm_pkg::FAMILY_W-1:0]   from_family;
   logic [fsgm_pkg::STAGE_FW-1:0]   stage;
   logic [fsgm_pkg::JOB_FW-1:0]     job_id;
   logic [fsgm_pkg::TVAL_W-1:0]     time_value;
   modport source (output valid, operation, family_id, from_family, stage, job_id,
                   time_value, input ready);
   modport sink (input valid, operation, family_id, from_family, stage, job_id,
                 time_value, output ready);
endinterface

interface fsgm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [fsgm_pkg::OUT_W-1:0]   makespan;
   logic [fsgm_pkg::OUT_W-1:0]   job_completion;
   logic                         status;
   modport source (output valid, makespan, job_completion, status, input ready);
   modport sink (input valid, makespan, job_completion, status, output ready);
endinterface

interface fsgm_csr_if;
   logic                              valid;
   logic                              ready;
   logic [fsgm_pkg::CSR_IDX_W-1:0]    index;
   logic [fsgm_pkg::CSR_DATA_W-1:0]   data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/flow_shop_group_makespan_top.sv
// ----------------------------------------------------------------------------
// flow_shop_group_makespan_top
// hybrid flow shop group schedule makespan evaluator
// ----------------------------------------------------------------------------
// usage
//   req_bus carries one transaction per item: table loads, clear, begin family
//   or add job; rsp_bus returns exactly one result transaction per request
//   csr_bus writes stage_count (index 0) and machines per stage (1..4); it is
//   always ready and should only be written while the block is idle
// timing
//   one request in flight; req_bus.ready is high only while the sequencer idles
//   load, clear and unused codes: dispatch (table write or clear), then the scan
//   begin family: for each stage, a setup ram read and a compare per machine,
//   then a commit; every compare goes through the single shared setup ram read port
//   add job: one process ram read and one ready time update per stage
//   makespan is rescanned over the last stage machines after every request
// reset
//   clears machine ready times, family marks and chosen machines, counts to one;
//   setup and process tables hold garbage until loaded
// backpressure
//   the result sits in an output register; a stalled rsp_bus holds it while
//   the next request is accepted and worked, then the sequencer waits in done
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module flow_shop_group_makespan_top (
   input  logic        clock,
   input  logic        reset,
   fsgm_req_if.sink    req_bus,
   fsgm_rsp_if.source  rsp_bus,
   fsgm_csr_if.sink    csr_bus
);

   fsgm_pkg::cmd_type  cmd;
   fsgm_pkg::stat_type stat;
   logic               req_ready;

   // register writes complete in the same cycle
   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = req_ready;

   // sequencer
   fsgm_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // tables, machine state and result register
   fsgm_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_operation      (req_bus.operation),
      .req_family_id      (req_bus.family_id),
      .req_from_family    (req_bus.from_family),
      .req_stage          (req_bus.stage),
      .req_job_id         (req_bus.job_id),
      .req_time_value     (req_bus.time_value),
      .csr_valid          (csr_bus.valid),
      .csr_index          (csr_bus.index),
      .csr_data           (csr_bus.data),
      .rsp_valid          (rsp_bus.valid),
      .rsp_ready          (rsp_bus.ready),
      .rsp_makespan       (rsp_bus.makespan),
      .rsp_job_completion (rsp_bus.job_completion),
      .rsp_status         (rsp_bus.status)
   );

endmodule

FILE: rtl/fsgm_ram.sv
// ----------------------------------------------------------------------------
// fsgm_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsgm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/fsgm_controller.sv
// ----------------------------------------------------------------------------
// fsgm_controller
// sequencer for table loads, family scans, job chains and makespan scans
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "flow_shop_group_makespan_top_macros.svh"

module fsgm_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  fsgm_pkg::stat_type  stat,
   output fsgm_pkg::cmd_type   cmd
);

   fsgm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fsgm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         fsgm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = fsgm_pkg::ST_DISPATCH;
            end
         end
         fsgm_pkg::ST_DISPATCH: begin
            case (stat.op)
               fsgm_pkg::OP_LOAD_SETUP, fsgm_pkg::OP_LOAD_PROC: begin
                  cmd.table_write = 1'b1;
                  state_in        = fsgm_pkg::ST_SCAN_START;
               end
               fsgm_pkg::OP_CLEAR: begin
                  cmd.clear_sched = 1'b1;
                  state_in        = fsgm_pkg::ST_SCAN_START;
               end
               fsgm_pkg::OP_BEGIN_FAM: begin
                  state_in = fsgm_pkg::ST_BEG_RD;
               end
               fsgm_pkg::OP_ADD_JOB: begin
                  if (stat.family_open) begin
                     state_in = fsgm_pkg::ST_JOB_RD;
                  end else begin
                     cmd.flag_no_family = 1'b1;
                     state_in           = fsgm_pkg::ST_SCAN_START;
                  end
               end
               default: begin
                  state_in = fsgm_pkg::ST_SCAN_START;
               end
            endcase
         end
         fsgm_pkg::ST_BEG_RD: begin
            state_in = fsgm_pkg::ST_BEG_CMP;
         end
         fsgm_pkg::ST_BEG_CMP: begin
            cmd.beg_compare = 1'b1;
            state_in = stat.last_machine ? fsgm_pkg::ST_BEG_WR : fsgm_pkg::ST_BEG_RD;
         end
         fsgm_pkg::ST_BEG_WR: begin
            cmd.beg_commit = 1'b1;
            state_in = stat.last_stage ? fsgm_pkg::ST_SCAN_START : fsgm_pkg::ST_BEG_RD;
         end
         fsgm_pkg::ST_JOB_RD: begin
            state_in = fsgm_pkg::ST_JOB_UPD;
         end
         fsgm_pkg::ST_JOB_UPD: begin
            cmd.job_update = 1'b1;
            state_in = stat.last_stage ? fsgm_pkg::ST_SCAN_START : fsgm_pkg::ST_JOB_RD;
         end
         fsgm_pkg::ST_SCAN_START: begin
            cmd.scan_start = 1'b1;
            state_in       = fsgm_pkg::ST_SCAN;
         end
         fsgm_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.last_scan) begin
               state_in = fsgm_pkg::ST_DONE;
            end
         end
         fsgm_pkg::ST_DONE: begin
            if (stat.rsp_free) begin
               cmd.load_result = 1'b1;
               state_in        = fsgm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fsgm_pkg::ST_IDLE;
         end
      endcase
   end

   `FSGM_ASSERT_NEXT(a_cmp_to_commit, state_ff == fsgm_pkg::ST_BEG_CMP && stat.last_machine, state_ff == fsgm_pkg::ST_BEG_WR, "last machine compare not followed by commit")
   `FSGM_ASSERT_NEXT(a_read_to_update, state_ff == fsgm_pkg::ST_JOB_RD, state_ff == fsgm_pkg::ST_JOB_UPD, "process read not followed by update")
   `FSGM_ASSERT_SAME(a_result_free, cmd.load_result, stat.rsp_free, "result register overwritten")

endmodule

FILE: rtl/fsgm_datapath.sv
// ----------------------------------------------------------------------------
// fsgm_datapath
// tables, machine state, counters and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsgm_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  fsgm_pkg::cmd_type                  cmd,
   output fsgm_pkg::stat_type                 stat,
   input  logic [fsgm_pkg::OP_W-1:0]          req_operation,
   input  logic [fsgm_pkg::FAMILY_W-1:0]      req_family_id,
   input  logic [fsgm_pkg::FAMILY_W-1:0]      req_from_family,
   input  logic [fsgm_pkg::STAGE_FW-1:0]      req_stage,
   input  logic [fsgm_pkg::JOB_FW-1:0]        req_job_id,
   input  logic [fsgm_pkg::TVAL_W-1:0]        req_time_value,
   input  logic                               csr_valid,
   input  logic [fsgm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fsgm_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [fsgm_pkg::OUT_W-1:0]         rsp_makespan,
   output logic [fsgm_pkg::OUT_W-1:0]         rsp_job_completion,
   output logic                               rsp_status
);

   localparam int TW = fsgm_pkg::TIME_WIDTH;

   // captured transaction
   logic [fsgm_pkg::OP_W-1:0]    op_ff, op_in;
   logic [fsgm_pkg::FAM_W-1:0]   fam_cap_ff, fam_cap_in;
   logic [fsgm_pkg::FAM_W-1:0]   from_ff, from_in;
   logic [fsgm_pkg::STAGE_W-1:0] stg_ff, stg_in;
   logic [fsgm_pkg::JOB_W-1:0]   job_ff, job_in;
   logic [fsgm_pkg::TVAL_W-1:0]  tv_ff, tv_in;

   // configuration
   logic [fsgm_pkg::CNT_W-1:0] stage_count_ff, stage_count_in;
   logic [fsgm_pkg::CNT_W-1:0] mach_cnt_ff [fsgm_pkg::MAX_STAGES];
   logic [fsgm_pkg::CNT_W-1:0] mach_cnt_in [fsgm_pkg::MAX_STAGES];

   // machine state
   logic [TW-1:0]                ready_ff [fsgm_pkg::NUM_SLOTS];
   logic [TW-1:0]                ready_in [fsgm_pkg::NUM_SLOTS];
   logic [fsgm_pkg::FAM_W-1:0]   lfam_ff  [fsgm_pkg::NUM_SLOTS];
   logic [fsgm_pkg::FAM_W-1:0]   lfam_in  [fsgm_pkg::NUM_SLOTS];
   logic [fsgm_pkg::NUM_SLOTS-1:0] lvalid_ff, lvalid_in;
   logic [fsgm_pkg::MACH_W-1:0]  chosen_ff [fsgm_pkg::MAX_STAGES];
   logic [fsgm_pkg::MACH_W-1:0]  chosen_in [fsgm_pkg::MAX_STAGES];
   logic                         open_ff, open_in;

   // sequencing and accumulators
   logic [fsgm_pkg::STAGE_W-1:0] s_ff, s_in;
   logic [fsgm_pkg::MACH_W-1:0]  m_ff, m_in;
   logic [TW-1:0]                best_ff, best_in;
   logic [fsgm_pkg::MACH_W-1:0]  sel_ff, sel_in;
   logic [TW-1:0]                prev_ff, prev_in;
   logic [TW-1:0]                ms_ff, ms_in;
   logic                         status_ff, status_in;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [fsgm_pkg::OUT_W-1:0]   rsp_ms_ff, rsp_ms_in;
   logic [fsgm_pkg::OUT_W-1:0]   rsp_done_ff, rsp_done_in;
   logic                         rsp_status_ff, rsp_status_in;

   logic [fsgm_pkg::STAGE_W-1:0] last_stg;
   logic [fsgm_pkg::SLOT_W-1:0]  rd_slot;
   logic [TW-1:0]                rd_ready;
   logic [fsgm_pkg::FAM_W-1:0]   prev_fam;
   logic [fsgm_pkg::TVAL_W-1:0]  setup_rd, proc_rd;
   logic [TW-1:0]                cand, start, job_done;
   logic                         rsp_free;
   logic                         is_job;

   assign last_stg = fsgm_pkg::STAGE_W'(stage_count_ff - fsgm_pkg::CNT_W'(1));

   always_comb begin
      if (cmd.scan_step) begin
         rd_slot = {last_stg, m_ff};
      end else if (cmd.job_update) begin
         rd_slot = {s_ff, chosen_ff[s_ff]};
      end else begin
         rd_slot = {s_ff, m_ff};
      end
   end

   assign rd_ready = ready_ff[rd_slot];
   assign prev_fam = lvalid_ff[rd_slot] ? lfam_ff[rd_slot] : fam_cap_ff;

   fsgm_ram #(
      .WIDTH (fsgm_pkg::TVAL_W),
      .DEPTH (fsgm_pkg::SETUP_DEPTH)
   ) u_setup_ram (
      .clock   (clock),
      .wr_en   (cmd.table_write && op_ff == fsgm_pkg::OP_LOAD_SETUP),
      .wr_addr ({stg_ff, from_ff, fam_cap_ff}),
      .wr_data (tv_ff),
      .rd_addr ({s_ff, prev_fam, fam_cap_ff}),
      .rd_data (setup_rd)
   );

   fsgm_ram #(
      .WIDTH (fsgm_pkg::TVAL_W),
      .DEPTH (fsgm_pkg::PROC_DEPTH)
   ) u_proc_ram (
      .clock   (clock),
      .wr_en   (cmd.table_write && op_ff == fsgm_pkg::OP_LOAD_PROC),
      .wr_addr ({job_ff, stg_ff}),
      .wr_data (tv_ff),
      .rd_addr ({job_ff, s_ff}),
      .rd_data (proc_rd)
   );

   assign cand     = fsgm_pkg::sat_add(rd_ready, setup_rd);
   assign start    = (prev_ff > rd_ready) ? prev_ff : rd_ready;
   assign job_done = fsgm_pkg::sat_add(start, proc_rd);
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign is_job   = op_ff == fsgm_pkg::OP_ADD_JOB;

   // capture and configuration
   always_comb begin
      op_in      = op_ff;
      fam_cap_in = fam_cap_ff;
      from_in    = from_ff;
      stg_in     = stg_ff;
      job_in     = job_ff;
      tv_in      = tv_ff;
      if (cmd.capture) begin
         op_in      = req_operation;
         fam_cap_in = req_family_id[fsgm_pkg::FAM_W-1:0];
         from_in    = req_from_family[fsgm_pkg::FAM_W-1:0];
         stg_in     = req_stage[fsgm_pkg::STAGE_W-1:0];
         job_in     = req_job_id[fsgm_pkg::JOB_W-1:0];
         tv_in      = req_time_value;
      end
      stage_count_in = stage_count_ff;
      mach_cnt_in    = mach_cnt_ff;
      if (csr_valid) begin
         if (csr_index == fsgm_pkg::REG_STAGE_COUNT) begin
            stage_count_in = fsgm_pkg::clamp_count(csr_data, fsgm_pkg::MAX_STAGES);
         end
         for (int i = 0; i < fsgm_pkg::MAX_STAGES; i++) begin
            if (csr_index == fsgm_pkg::CSR_IDX_W'(fsgm_pkg::REG_MACH_BASE + i)) begin
               mach_cnt_in[i] = fsgm_pkg::clamp_count(csr_data, fsgm_pkg::MAX_MACHINES);
            end
         end
      end
   end

   // machine state updates
   always_comb begin
      ready_in  = ready_ff;
      lfam_in   = lfam_ff;
      lvalid_in = lvalid_ff;
      chosen_in = chosen_ff;
      open_in   = open_ff;
      if (cmd.clear_sched) begin
         for (int i = 0; i < fsgm_pkg::NUM_SLOTS; i++) begin
            ready_in[i] = '0;
         end
         for (int i = 0; i < fsgm_pkg::MAX_STAGES; i++) begin
            chosen_in[i] = '0;
         end
         lvalid_in = '0;
         open_in   = 1'b0;
      end
      if (cmd.beg_commit) begin
         ready_in[{s_ff, sel_ff}]  = best_ff;
         lfam_in[{s_ff, sel_ff}]   = fam_cap_ff;
         lvalid_in[{s_ff, sel_ff}] = 1'b1;
         chosen_in[s_ff]           = sel_ff;
         open_in                   = 1'b1;
      end
      if (cmd.job_update) begin
         ready_in[rd_slot] = job_done;
      end
   end

   // counters and accumulators
   always_comb begin
      s_in      = s_ff;
      m_in      = m_ff;
      best_in   = best_ff;
      sel_in    = sel_ff;
      prev_in   = prev_ff;
      ms_in     = ms_ff;
      status_in = status_ff;
      if (cmd.capture) begin
         s_in      = '0;
         m_in      = '0;
         prev_in   = '0;
         status_in = 1'b0;
      end
      if (cmd.flag_no_family) begin
         status_in = 1'b1;
      end
      if (cmd.beg_compare) begin
         if (m_ff == '0 || cand < best_ff) begin
            best_in = cand;
            sel_in  = m_ff;
         end
         if (!stat.last_machine) begin
            m_in = m_ff + fsgm_pkg::MACH_W'(1);
         end
      end
      if (cmd.beg_commit) begin
         s_in = s_ff + fsgm_pkg::STAGE_W'(1);
         m_in = '0;
      end
      if (cmd.job_update) begin
         prev_in = job_done;
         s_in    = s_ff + fsgm_pkg::STAGE_W'(1);
      end
      if (cmd.scan_start) begin
         m_in  = '0;
         ms_in = '0;
      end
      if (cmd.scan_step) begin
         if (rd_ready > ms_ff) begin
            ms_in = rd_ready;
         end
         if (!stat.last_scan) begin
            m_in = m_ff + fsgm_pkg::MACH_W'(1);
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_ms_in     = rsp_ms_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_result) begin
         rsp_valid_in  = 1'b1;
         rsp_ms_in     = fsgm_pkg::OUT_W'(ms_ff);
         rsp_done_in   = (is_job && !status_ff) ? fsgm_pkg::OUT_W'(prev_ff) : '0;
         rsp_status_in = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      fam_cap_ff    <= fam_cap_in;
      from_ff       <= from_in;
      stg_ff        <= stg_in;
      job_ff        <= job_in;
      tv_ff         <= tv_in;
      lfam_ff       <= lfam_in;
      s_ff          <= s_in;
      m_ff          <= m_in;
      best_ff       <= best_in;
      sel_ff        <= sel_in;
      prev_ff       <= prev_in;
      ms_ff         <= ms_in;
      status_ff     <= status_in;
      rsp_ms_ff     <= rsp_ms_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         stage_count_ff <= fsgm_pkg::CNT_W'(1);
         for (int i = 0; i < fsgm_pkg::MAX_STAGES; i++) begin
            mach_cnt_ff[i] <= fsgm_pkg::CNT_W'(1);
            chosen_ff[i]   <= '0;
         end
         for (int i = 0; i < fsgm_pkg::NUM_SLOTS; i++) begin
            ready_ff[i] <= '0;
         end
         lvalid_ff    <= '0;
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stage_count_ff <= stage_count_in;
         mach_cnt_ff    <= mach_cnt_in;
         chosen_ff      <= chosen_in;
         ready_ff       <= ready_in;
         lvalid_ff      <= lvalid_in;
         open_ff        <= open_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_comb begin
      stat              = '0;
      stat.op           = op_ff;
      stat.family_open  = open_ff;
      stat.last_machine = (fsgm_pkg::CNT_W'(m_ff) + fsgm_pkg::CNT_W'(1)) == mach_cnt_ff[s_ff];
      stat.last_stage   = (fsgm_pkg::CNT_W'(s_ff) + fsgm_pkg::CNT_W'(1)) == stage_count_ff;
      stat.last_scan    = (fsgm_pkg::CNT_W'(m_ff) + fsgm_pkg::CNT_W'(1)) ==
                          mach_cnt_ff[last_stg];
      stat.rsp_free     = rsp_free;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_makespan       = rsp_ms_ff;
   assign rsp_job_completion = rsp_done_ff;
   assign rsp_status         = rsp_status_ff;

endmodule
